// ----- sv/stftdb_pkg.sv -----
// ----------------------------------------------------------------------------
// stftdb_pkg
// Shared types, codes and constants of the short-time power spectrum engine.
// ----------------------------------------------------------------------------
`default_nettype none

package stftdb_pkg;

  localparam int unsigned PTR_W  = 12;   // ring slot / coefficient index, widest size
  localparam int unsigned FILL_W = 13;   // fill offset and tail length

  localparam logic [1:0] REQ_COEF   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  localparam logic [FILL_W-1:0] FILL_CAP = 13'd8191;

  localparam logic [63:0] PI4_Q32 = 64'd3373259426;
  localparam logic [63:0] ONE_Q32 = 64'd4294967296;
  localparam logic [63:0] EPS_E82 = 64'd4835703;
  localparam logic [63:0] EPS_E80 = 64'd1208926;
  localparam logic signed [63:0] DB_PER_OCT_Q24 = 64'sd50504453;
  localparam logic signed [63:0] DB_MIN = -64'sd46080;
  localparam logic signed [63:0] DB_MAX = 64'sd8191;

  typedef enum logic [1:0] {
    CMD_COEF,
    CMD_SAMPLE,
    CMD_FLUSH
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [15:0]       data;
    logic [PTR_W-1:0]  addr;
    logic              frame;
    logic [FILL_W-1:0] avail;
  } cmd_t;

  typedef struct packed {
    logic [5:0]         bin_index;
    logic signed [16:0] level_db;
    logic               padded_frame;
    logic               last_bin;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN,
    ST_DFT,
    ST_ROUND,
    ST_SQUARE,
    ST_SUM,
    ST_NORM,
    ST_LOG,
    ST_SCALE,
    ST_CLAMP,
    ST_EMIT
  } back_state_e;

  // Q1.30 twiddle for angle 2*pi*m/2^lg, octant Taylor series in Q.32.
  function automatic logic signed [31:0] twiddle(input int unsigned m,
                                                 input int unsigned lg,
                                                 input logic want_sin);
    logic [63:0] quarter, eighth, q, u, v, phi, p, t, s_raw, c_raw;
    logic [31:0] s, c, s0, c0, cv, sv;
    quarter = 64'd1 << (lg - 2);
    eighth  = 64'd1 << (lg - 3);
    q = 64'(m) >> (lg - 2);
    u = 64'(m) & (quarter - 64'd1);
    v = (u <= eighth) ? u : quarter - u;
    phi = (v * 64'd8 * PI4_Q32) >> lg;
    p = (phi * phi) >> 32;
    t = ONE_Q32;
    t = ONE_Q32 - (((p * t) >> 32) / 64'd210);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd156);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd110);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd72);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd42);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd20);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd6);
    s_raw = (phi * t) >> 32;
    t = ONE_Q32;
    t = ONE_Q32 - (((p * t) >> 32) / 64'd240);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd182);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd132);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd90);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd56);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd30);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd12);
    t = ONE_Q32 - (((p * t) >> 32) / 64'd2);
    c_raw = t;
    s = 32'((s_raw + 64'd2) >> 2);
    c = 32'((c_raw + 64'd2) >> 2);
    if (u <= eighth) begin
      s0 = s;
      c0 = c;
    end else begin
      s0 = c;
      c0 = s;
    end
    case (q[1:0])
      2'd0: begin
        cv = c0;
        sv = s0;
      end
      2'd1: begin
        cv = 32'(-s0);
        sv = c0;
      end
      2'd2: begin
        cv = 32'(-c0);
        sv = 32'(-s0);
      end
      default: begin
        cv = s0;
        sv = 32'(-c0);
      end
    endcase
    twiddle = want_sin ? $signed(sv) : $signed(cv);
  endfunction

endpackage

`default_nettype wire

// ----- sv/stft_power_spectrum_db.sv -----
// ----------------------------------------------------------------------------
// stft_power_spectrum_db
// Short-time power spectrum engine with dB output in Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//  - Input queue: drive push with req_type_i and its fields; a beat is taken
//    when push is high and full is low. Window loads, samples and flushes
//    all go through this one channel, in order.
//  - Result queue: while empty is low the oldest bin sits on the result
//    ports; pop takes it. A frame gives FFT_SIZE/2+1 beats, last_bin on the
//    final one, padded_frame on the tail frame of a flush.
//  - Config: cfg_valid_i/cfg_ready_o write hop_size (0 acts as FFT_SIZE/2).
//    Write it only while idle.
//  - Order of work: a frame command is popped and the ring windowed, then
//    each bin runs one complex MAC a cycle in the direct DFT, a normalize
//    loop of 1 to 12 steps and 16 squaring steps of the log. The back end
//    takes no new command until the last bin of a frame is queued; items
//    that cause no frame pass the front combinationally.
//  - Reset clears stream counters and queues; ring and window stay unknown
//    until written.
//  - A stalled result side backs up the back end, then the command queue,
//    and finally raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module stft_power_spectrum_db #(
  parameter int unsigned FFT_SIZE = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [10:0]        cfg_data_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         req_type_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic [5:0]         coef_index_i,
  input  wire logic signed [15:0] coef_value_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [5:0]              bin_index_o,
  output logic signed [16:0]      level_db_o,
  output logic                    padded_frame_o,
  output logic                    last_bin_o
);

  localparam int unsigned LOG2N = $clog2(FFT_SIZE);

  stftdb_pkg::cmd_t cmd_in, cmd_out;
  stftdb_pkg::res_t res_in, res_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty, res_push, res_full;
  logic in_take;

  // config register is always ready
  assign cfg_ready_o = 1'b1;
  assign in_take     = push && !full;
  assign full        = cmd_full;

  stftdb_front #(
    .FFT_SIZE(FFT_SIZE),
    .LOG2N   (LOG2N)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_take),
    .req_type_i  (req_type_i),
    .sample_i    (sample_i),
    .coef_index_i(coef_index_i),
    .coef_value_i(coef_value_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  // command queue decouples classification from the transform
  stftdb_fifo #(
    .WIDTH($bits(stftdb_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  stftdb_back #(
    .FFT_SIZE(FFT_SIZE),
    .LOG2N   (LOG2N)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // result queue holds finished bins while the receiver stalls
  stftdb_fifo #(
    .WIDTH($bits(stftdb_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign bin_index_o    = res_out.bin_index;
  assign level_db_o     = res_out.level_db;
  assign padded_frame_o = res_out.padded_frame;
  assign last_bin_o     = res_out.last_bin;

endmodule

`default_nettype wire

// ----- sv/stftdb_fifo.sv -----
// ----------------------------------------------------------------------------
// stftdb_fifo
// Small register queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module stftdb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/stftdb_front.sv -----
// ----------------------------------------------------------------------------
// stftdb_front
// Classifies requests, keeps the stream counters and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module stftdb_front #(
  parameter int unsigned FFT_SIZE = 64,
  parameter int unsigned LOG2N    = 6
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [10:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  input  wire logic [1:0]          req_type_i,
  input  wire logic signed [15:0]  sample_i,
  input  wire logic [5:0]          coef_index_i,
  input  wire logic signed [15:0]  coef_value_i,
  output logic                     cmd_push_o,
  output stftdb_pkg::cmd_t         cmd_o
);

  localparam int unsigned FW = stftdb_pkg::FILL_W;
  localparam logic [FW-1:0] N_F = FW'(FFT_SIZE);

  logic [10:0]      hop_q;
  logic [LOG2N-1:0] rp_q, rp_d;
  logic [FW-1:0]    fo_q, fo_d, fo_inc, hop_ext, avail;
  logic             fe_q, fe_d;
  logic [11:0]      hop_eff;
  logic [LOG2N+5:0] cidx_ext;

  assign hop_eff  = (hop_q == '0) ? 12'(FFT_SIZE / 2) : {1'b0, hop_q};
  assign hop_ext  = FW'(hop_eff);
  assign fo_inc   = (fo_q < stftdb_pkg::FILL_CAP) ? fo_q + FW'(1) : fo_q;
  assign cidx_ext = (LOG2N + 6)'(coef_index_i);

  always_comb begin
    avail = '0;
    if (fe_q) begin
      if (fo_q > N_F && fo_q > hop_ext) begin
        avail = fo_q - hop_ext;
      end
    end else begin
      avail = fo_q;
    end
    if (avail > N_F) begin
      avail = N_F;
    end
  end

  always_comb begin
    rp_d       = rp_q;
    fo_d       = fo_q;
    fe_d       = fe_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.addr = stftdb_pkg::PTR_W'(rp_q);
    if (in_valid_i) begin
      case (req_type_i)
        stftdb_pkg::REQ_COEF: begin
          cmd_push_o = 1'b1;
          cmd_o.op   = stftdb_pkg::CMD_COEF;
          cmd_o.data = coef_value_i;
          cmd_o.addr = stftdb_pkg::PTR_W'(cidx_ext[LOG2N-1:0]);
        end
        stftdb_pkg::REQ_SAMPLE: begin
          cmd_push_o = 1'b1;
          cmd_o.op   = stftdb_pkg::CMD_SAMPLE;
          cmd_o.data = sample_i;
          rp_d       = rp_q + LOG2N'(1);
          fo_d       = fo_inc;
          if (!fe_q && fo_inc >= N_F) begin
            fe_d        = 1'b1;
            cmd_o.frame = 1'b1;
          end else if (fe_q && fo_inc >= hop_ext + N_F) begin
            fo_d        = fo_inc - hop_ext;
            cmd_o.frame = 1'b1;
          end
        end
        stftdb_pkg::REQ_FLUSH: begin
          cmd_push_o  = (avail != '0);
          cmd_o.op    = stftdb_pkg::CMD_FLUSH;
          cmd_o.frame = 1'b1;
          cmd_o.avail = avail;
          rp_d        = '0;
          fo_d        = '0;
          fe_d        = 1'b0;
        end
        default: begin
          // drop unknown request
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_q <= 11'd32;
      rp_q  <= '0;
      fo_q  <= '0;
      fe_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        hop_q <= cfg_data_i;
      end
      rp_q <= rp_d;
      fo_q <= fo_d;
      fe_q <= fe_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/stftdb_back.sv -----
// ----------------------------------------------------------------------------
// stftdb_back
// Executes commands: ring and window writes, windowing, direct DFT per bin,
// power and log-domain conversion to Q8.8 dB.
// ----------------------------------------------------------------------------
`default_nettype none

module stftdb_back #(
  parameter int unsigned FFT_SIZE = 64,
  parameter int unsigned LOG2N    = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_empty_i,
  input  stftdb_pkg::cmd_t       cmd_i,
  output logic                   cmd_pop_o,
  input  wire logic              res_full_i,
  output logic                   res_push_o,
  output stftdb_pkg::res_t       res_o
);

  localparam int unsigned CW = LOG2N + 2;
  localparam logic [CW-1:0] N_C  = CW'(FFT_SIZE);
  localparam logic [CW-1:0] N2_C = CW'(FFT_SIZE + 2);
  localparam logic [LOG2N-1:0] K_LAST = LOG2N'(FFT_SIZE / 2);
  localparam int unsigned SH = 16 + LOG2N;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (SH - 1);

  stftdb_pkg::back_state_e state_q, state_d;

  logic signed [15:0] ring_mem [FFT_SIZE];
  logic signed [15:0] win_mem  [FFT_SIZE];
  logic signed [17:0] wf_mem   [FFT_SIZE];
  logic signed [31:0] cos_rom  [FFT_SIZE];
  logic signed [31:0] sin_rom  [FFT_SIZE];

  for (genvar g = 0; g < FFT_SIZE; g++) begin : g_rom
    localparam logic signed [31:0] CV = stftdb_pkg::twiddle(g, LOG2N, 1'b0);
    localparam logic signed [31:0] SV = stftdb_pkg::twiddle(g, LOG2N, 1'b1);
    assign cos_rom[g] = CV;
    assign sin_rom[g] = SV;
  end

  logic [LOG2N-1:0] k_q, idx_q, rp_q, rd_i_q, cnt_i, slot, wa;
  logic [CW-1:0]    cnt_q;
  logic [LOG2N:0]   avail_q, slot_full;
  logic             padded_q, rd_v_q, rd_zero_q, v1_q, v2_q;
  logic             ring_we, win_we, interior, frame_cmd;
  logic signed [15:0] ring_rd_q, win_rd_q;
  logic signed [31:0] wprod;
  logic signed [32:0] wsum;
  logic signed [17:0] wx;
  logic signed [17:0] wf_rd_q;
  logic signed [31:0] cos_rd_q, sin_rd_q, re_q, im_q;
  logic signed [49:0] pr_re_q, pr_im_q;
  logic signed [63:0] acc_re_q, acc_im_q, sum_re, sum_im, sq_re_q, sq_im_q;
  logic signed [63:0] scl_q, dbw;
  logic [63:0]        pw, t_q, m2;
  logic [6:0]         e_q;
  logic [5:0]         msb_q;
  logic [31:0]        mant_q;
  logic [32:0]        sqr;
  logic [15:0]        frac_q;
  logic [3:0]         it_q;
  logic signed [7:0]  diff;
  logic signed [23:0] lq;
  logic signed [16:0] level_q;
  logic [LOG2N+5:0]   k_ext;

  assign cnt_i     = cnt_q[LOG2N-1:0];
  assign slot_full = (LOG2N + 1)'(rp_q) + (LOG2N + 1)'(cnt_i) - avail_q;
  assign slot      = slot_full[LOG2N-1:0];
  assign wa        = cmd_i.addr[LOG2N-1:0];
  assign interior  = (k_q != '0) && (k_q != K_LAST);
  assign frame_cmd = cmd_i.frame &&
                     (cmd_i.op == stftdb_pkg::CMD_SAMPLE || cmd_i.op == stftdb_pkg::CMD_FLUSH);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stftdb_pkg::ST_IDLE:   if (!cmd_empty_i && frame_cmd) state_d = stftdb_pkg::ST_WIN;
      stftdb_pkg::ST_WIN:    if (cnt_q == N_C) state_d = stftdb_pkg::ST_DFT;
      stftdb_pkg::ST_DFT:    if (cnt_q == N2_C) state_d = stftdb_pkg::ST_ROUND;
      stftdb_pkg::ST_ROUND:  state_d = stftdb_pkg::ST_SQUARE;
      stftdb_pkg::ST_SQUARE: state_d = stftdb_pkg::ST_SUM;
      stftdb_pkg::ST_SUM:    state_d = stftdb_pkg::ST_NORM;
      stftdb_pkg::ST_NORM:   if (t_q[63]) state_d = stftdb_pkg::ST_LOG;
      stftdb_pkg::ST_LOG:    if (it_q == 4'd15) state_d = stftdb_pkg::ST_SCALE;
      stftdb_pkg::ST_SCALE:  state_d = stftdb_pkg::ST_CLAMP;
      stftdb_pkg::ST_CLAMP:  state_d = stftdb_pkg::ST_EMIT;
      stftdb_pkg::ST_EMIT: begin
        if (!res_full_i) begin
          state_d = (k_q == K_LAST) ? stftdb_pkg::ST_IDLE : stftdb_pkg::ST_DFT;
        end
      end
      default: state_d = stftdb_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o  = (state_q == stftdb_pkg::ST_IDLE) && !cmd_empty_i;
    res_push_o = (state_q == stftdb_pkg::ST_EMIT) && !res_full_i;
    ring_we    = cmd_pop_o && (cmd_i.op == stftdb_pkg::CMD_SAMPLE);
    win_we     = cmd_pop_o && (cmd_i.op == stftdb_pkg::CMD_COEF);
  end

  assign k_ext              = (LOG2N + 6)'(k_q);
  assign res_o.bin_index    = k_ext[5:0];
  assign res_o.level_db     = level_q;
  assign res_o.padded_frame = padded_q;
  assign res_o.last_bin     = (k_q == K_LAST);

  // memories
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wa] <= cmd_i.data;
    end
    ring_rd_q <= ring_mem[slot];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[wa] <= cmd_i.data;
    end
    win_rd_q <= win_mem[cnt_i];
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      wf_mem[rd_i_q] <= wx;
    end
    wf_rd_q <= wf_mem[cnt_i];
  end

  always_ff @(posedge clk_i) begin
    cos_rd_q <= cos_rom[idx_q];
    sin_rd_q <= sin_rom[idx_q];
  end

  // windowing: round half up of sample*coef / 2^14
  assign wprod = ring_rd_q * win_rd_q;
  assign wsum  = 33'(wprod) + 33'sd8192;
  assign wx    = rd_zero_q ? '0 : wsum[31:14];

  assign sum_re = acc_re_q + HALF;
  assign sum_im = HALF - acc_im_q;
  assign pw     = 64'(sq_re_q) + 64'(sq_im_q);
  assign m2     = mant_q * mant_q;
  assign sqr    = m2[63:31];
  assign diff   = $signed({2'b00, msb_q}) - $signed({1'b0, e_q});
  assign lq     = $signed({diff, frac_q});
  assign dbw    = (scl_q + 64'sd2147483648) >>> 32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stftdb_pkg::ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      idx_q   <= '0;
      rd_v_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == stftdb_pkg::ST_WIN) && (cnt_q < N_C);
      v1_q    <= (state_q == stftdb_pkg::ST_DFT) && (cnt_q < N_C);
      v2_q    <= v1_q;
      case (state_q)
        stftdb_pkg::ST_IDLE: cnt_q <= '0;
        stftdb_pkg::ST_WIN: begin
          if (cnt_q == N_C) begin
            cnt_q <= '0;
            k_q   <= '0;
            idx_q <= '0;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        stftdb_pkg::ST_DFT: begin
          if (cnt_q < N_C) begin
            idx_q <= idx_q + k_q;
          end
          cnt_q <= cnt_q + CW'(1);
        end
        stftdb_pkg::ST_EMIT: begin
          if (!res_full_i && k_q != K_LAST) begin
            k_q   <= k_q + LOG2N'(1);
            cnt_q <= '0;
            idx_q <= '0;
          end
        end
        default: begin
          // hold
        end
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    rd_i_q    <= cnt_i;
    rd_zero_q <= (cnt_q[LOG2N:0] >= avail_q);
    pr_re_q   <= wf_rd_q * cos_rd_q;
    pr_im_q   <= wf_rd_q * sin_rd_q;
    case (state_q)
      stftdb_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          padded_q <= (cmd_i.op == stftdb_pkg::CMD_FLUSH);
          if (cmd_i.op == stftdb_pkg::CMD_FLUSH) begin
            rp_q    <= wa;
            avail_q <= cmd_i.avail[LOG2N:0];
          end else begin
            rp_q    <= wa + LOG2N'(1);
            avail_q <= (LOG2N + 1)'(FFT_SIZE);
          end
        end
      end
      stftdb_pkg::ST_WIN: begin
        acc_re_q <= '0;
        acc_im_q <= '0;
      end
      stftdb_pkg::ST_DFT: begin
        if (v2_q) begin
          acc_re_q <= acc_re_q + 64'(pr_re_q);
          acc_im_q <= acc_im_q + 64'(pr_im_q);
        end
      end
      stftdb_pkg::ST_ROUND: begin
        re_q <= 32'(sum_re >>> SH);
        im_q <= 32'(sum_im >>> SH);
      end
      stftdb_pkg::ST_SQUARE: begin
        sq_re_q <= re_q * re_q;
        sq_im_q <= im_q * im_q;
      end
      stftdb_pkg::ST_SUM: begin
        msb_q <= 6'd63;
        if (pw[63:32] == '0) begin
          t_q <= (pw << 24) + (interior ? stftdb_pkg::EPS_E80 : stftdb_pkg::EPS_E82);
          e_q <= interior ? 7'd80 : 7'd82;
        end else begin
          t_q <= pw;
          e_q <= interior ? 7'd56 : 7'd58;
        end
      end
      stftdb_pkg::ST_NORM: begin
        if (t_q[63:56] == '0) begin
          t_q   <= t_q << 8;
          msb_q <= msb_q - 6'd8;
        end else if (!t_q[63]) begin
          t_q   <= t_q << 1;
          msb_q <= msb_q - 6'd1;
        end else begin
          mant_q <= t_q[63:32];
          frac_q <= '0;
          it_q   <= '0;
        end
      end
      stftdb_pkg::ST_LOG: begin
        mant_q <= sqr[32] ? sqr[32:1] : sqr[31:0];
        frac_q <= {frac_q[14:0], sqr[32]};
        it_q   <= it_q + 4'd1;
      end
      stftdb_pkg::ST_SCALE: scl_q <= lq * stftdb_pkg::DB_PER_OCT_Q24;
      stftdb_pkg::ST_CLAMP: begin
        if (dbw < stftdb_pkg::DB_MIN) begin
          level_q <= 17'(stftdb_pkg::DB_MIN);
        end else if (dbw > stftdb_pkg::DB_MAX) begin
          level_q <= 17'(stftdb_pkg::DB_MAX);
        end else begin
          level_q <= 17'(dbw);
        end
      end
      stftdb_pkg::ST_EMIT: begin
        acc_re_q <= '0;
        acc_im_q <= '0;
      end
      default: begin
        // hold
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the short-time power spectrum engine. Every beat
// taken on the input queue runs through a bit-true spectrum predictor. The
// predictor queues the bins it expects, and each popped bin is compared with
// the oldest one in that queue. Directed phases cover window loads, sample
// extremes, padded tails, tail capping, ignored requests, extreme hop sizes
// and a long result stall. A random phase follows.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned N_PTS      = 64;
  localparam int unsigned N_BINS     = N_PTS / 2 + 1;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam int          WD_LIMIT   = 60000;  // idle cycles before giving up
  localparam int          SETTLE     = 100;    // cycles after the last bin
  localparam int          LONG_HOLD  = 20000;  // receiver hold-off under pressure

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [10:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic [1:0] req_type_i = '0;
  logic signed [15:0] sample_i = '0;
  logic [5:0] coef_index_i = '0;
  logic signed [15:0] coef_value_i = '0;
  logic pop = 1'b0;
  logic cfg_ready_o, full, empty, padded_frame_o, last_bin_o;
  logic [5:0] bin_index_o;
  logic signed [16:0] level_db_o;

  stft_power_spectrum_db u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .push, .full, .req_type_i, .sample_i, .coef_index_i, .coef_value_i,
    .empty, .pop, .bin_index_o, .level_db_o, .padded_frame_o, .last_bin_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: a private copy of the stream and the hop register.
  logic signed [15:0] ring_q[N_PTS];
  logic signed [15:0] win_q[N_PTS];
  logic signed [31:0] cos_q[N_PTS];
  logic signed [31:0] sin_q[N_PTS];
  int unsigned wr_slot, fill_cnt, hop_reg;
  bit          framed;
  stftdb_pkg::res_t bins_due[$];

  int  fail_cnt = 0;
  bit  no_idle = 1'b0;
  bit  hold_long = 1'b0;
  int  quiet_cnt = 0;

  // Taylor series of sin/cos on the first octant, Q.32 in, Q1.30 out.
  function automatic void octant_trig(input logic [63:0] phi,
                                      output logic [31:0] s, output logic [31:0] c);
    int unsigned sdiv[7] = '{210, 156, 110, 72, 42, 20, 6};
    int unsigned cdiv[8] = '{240, 182, 132, 90, 56, 30, 12, 2};
    logic [63:0] p, t;
    p = (phi * phi) >> 32;
    t = stftdb_pkg::ONE_Q32;
    foreach (sdiv[i]) t = stftdb_pkg::ONE_Q32 - ((p * t) >> 32) / 64'(sdiv[i]);
    s = 32'((((phi * t) >> 32) + 64'd2) >> 2);
    t = stftdb_pkg::ONE_Q32;
    foreach (cdiv[i]) t = stftdb_pkg::ONE_Q32 - ((p * t) >> 32) / 64'(cdiv[i]);
    c = 32'((t + 64'd2) >> 2);
  endfunction

  function automatic void build_trig();
    int unsigned qd, u, v;
    logic [63:0] phi;
    logic [31:0] s, c, s0, c0;
    for (int unsigned m = 0; m < N_PTS; m++) begin
      qd = m / (N_PTS / 4);
      u = m % (N_PTS / 4);
      v = (u <= N_PTS / 8) ? u : N_PTS / 4 - u;
      phi = (64'(v) * 64'd8 * stftdb_pkg::PI4_Q32) / 64'(N_PTS);
      octant_trig(phi, s, c);
      if (u <= N_PTS / 8) begin
        s0 = s;
        c0 = c;
      end else begin
        s0 = c;
        c0 = s;
      end
      case (qd & 3)
        0: begin
          cos_q[m] = c0;
          sin_q[m] = s0;
        end
        1: begin
          cos_q[m] = -s0;
          sin_q[m] = c0;
        end
        2: begin
          cos_q[m] = -c0;
          sin_q[m] = -s0;
        end
        default: begin
          cos_q[m] = s0;
          sin_q[m] = -c0;
        end
      endcase
    end
  endfunction

  // Power (Q.58, or Q.56 for interior bins) to dB in Q8.8.
  function automatic logic signed [16:0] power_db(input logic [63:0] pw, input bit interior);
    logic [63:0] t, mant;
    int e, msb;
    logic [31:0] frac;
    longint lq, db;
    e = interior ? 56 : 58;
    frac = '0;
    if (pw < stftdb_pkg::ONE_Q32) begin
      t = (pw << 24) + (interior ? stftdb_pkg::EPS_E80 : stftdb_pkg::EPS_E82);
      e += 24;
    end else begin
      t = pw;
    end
    msb = 63;
    while (msb > 0 && t[msb] == 1'b0) msb--;
    mant = (msb >= 31) ? (t >> (msb - 31)) : (t << (31 - msb));
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= stftdb_pkg::ONE_Q32) begin
        mant = mant >> 1;
        frac[0] = 1'b1;
      end
    end
    lq = longint'(msb - e) * 65536 + longint'(frac);
    db = (lq * 64'sd50504453 + (64'sd1 <<< 31)) >>> 32;
    if (db < -46080) db = -46080;
    if (db > 8191) db = 8191;
    return db[16:0];
  endfunction

  // Window the newest avail samples, run the DFT and queue every bin.
  function automatic void queue_frame(input int unsigned avail, input bit padded);
    longint xw[N_PTS];
    longint re, im;
    logic signed [31:0] rr, ii;
    int unsigned slot, idx;
    logic [63:0] pw;
    stftdb_pkg::res_t r;
    for (int unsigned i = 0; i < N_PTS; i++) begin
      if (i < avail) begin
        slot = (wr_slot - avail + i) & (N_PTS - 1);
        xw[i] = (longint'(ring_q[slot]) * longint'(win_q[i]) + 8192) >>> 14;
      end else begin
        xw[i] = 0;
      end
    end
    for (int unsigned k = 0; k < N_BINS; k++) begin
      re = 0;
      im = 0;
      idx = 0;
      for (int unsigned n = 0; n < N_PTS; n++) begin
        re += xw[n] * longint'(cos_q[idx]);
        im += xw[n] * longint'(sin_q[idx]);
        idx = (idx + k) & (N_PTS - 1);
      end
      rr = 32'((re + (64'sd1 <<< 21)) >>> 22);
      ii = 32'((-im + (64'sd1 <<< 21)) >>> 22);
      pw = 64'(longint'(rr) * longint'(rr)) + 64'(longint'(ii) * longint'(ii));
      r.bin_index    = 6'(k);
      r.level_db     = power_db(pw, k > 0 && k < N_BINS - 1);
      r.padded_frame = padded;
      r.last_bin     = (k == N_BINS - 1);
      bins_due = {bins_due, r};
    end
  endfunction

  function automatic void spectrum_step(input logic [1:0] rt, input logic signed [15:0] s,
                                        input logic [5:0] ci, input logic signed [15:0] cv);
    int unsigned hop, avail;
    hop = (hop_reg == 0) ? N_PTS / 2 : hop_reg;
    case (rt)
      stftdb_pkg::REQ_COEF: win_q[ci] = cv;
      stftdb_pkg::REQ_SAMPLE: begin
        ring_q[wr_slot] = s;
        wr_slot = (wr_slot + 1) & (N_PTS - 1);
        if (fill_cnt < 8191) fill_cnt++;
        if (!framed && fill_cnt >= N_PTS) begin
          framed = 1'b1;
          queue_frame(N_PTS, 1'b0);
        end else if (framed && fill_cnt >= hop + N_PTS) begin
          fill_cnt -= hop;
          queue_frame(N_PTS, 1'b0);
        end
      end
      stftdb_pkg::REQ_FLUSH: begin
        avail = 0;
        if (framed) begin
          if (fill_cnt > N_PTS && fill_cnt > hop) avail = fill_cnt - hop;
        end else begin
          avail = fill_cnt;
        end
        if (avail > N_PTS) avail = N_PTS;
        if (avail > 0) queue_frame(avail, 1'b1);
        wr_slot = 0;
        fill_cnt = 0;
        framed = 1'b0;
      end
      default: ;  // unused request code: drop it
    endcase
  endfunction

  // Offer one beat, sometimes with a random gap in front of it, and hold it until taken.
  task automatic send_item(input logic [1:0] rt, input logic signed [15:0] s,
                           input logic [5:0] ci, input logic signed [15:0] cv);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= rt;
    sample_i <= s;
    coef_index_i <= ci;
    coef_value_i <= cv;
    do @(posedge clk_i); while (full);
    spectrum_step(rt, s, ci, cv);
  endtask

  task automatic send_sample(input logic signed [15:0] s);
    send_item(stftdb_pkg::REQ_SAMPLE, s, 6'($urandom), 16'($urandom));
  endtask

  task automatic send_flush();
    send_item(stftdb_pkg::REQ_FLUSH, 16'($urandom), 6'($urandom), 16'($urandom));
  endtask

  // Lower push, then wait until every expected bin is out and the back end
  // has had time to settle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (bins_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_hop(input logic [10:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    hop_reg = v;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load all entries so that no frame ever reads an unwritten coefficient.
  task automatic test_window_load();
    for (int i = 0; i < N_PTS; i++) begin
      logic signed [15:0] cv;
      cv = 16'($urandom);
      if (i == 0) cv = 16'sh8000;
      if (i == 1) cv = 16'sh7fff;
      if (i == 2) cv = 16'sh0000;
      if (i == 3) cv = 16'sh4000;
      send_item(stftdb_pkg::REQ_COEF, 16'($urandom), 6'(i), cv);
    end
    drain();
  endtask

  // Ignored code, sample extremes in a short padded tail, then an empty flush.
  task automatic test_tail_frames();
    send_item(REQ_UNUSED, 16'($urandom), 6'($urandom), 16'($urandom));
    for (int i = 0; i < 3; i++) send_sample(i[0] ? 16'sh7fff : 16'sh8000);
    send_flush();
    send_flush();  // nothing left: no bins, stream restarts anyway
    drain();
  endtask

  // Hop of zero acts as half a frame; the first frame comes after a full
  // frame of samples. Then the largest hop keeps the next frame far away.
  task automatic test_hop_extremes();
    write_hop(11'd0);
    for (int i = 0; i < N_PTS + 2; i++) begin
      if (i < 3) send_sample(16'sh0000);
      else if (i < 24) send_sample(i[0] ? 16'sh7fff : 16'sh8000);
      else send_sample(16'($urandom));
    end
    drain();
    write_hop(11'd2047);
    send_sample(16'($urandom));
    drain();
  endtask

  // Hop of one gives a frame per sample; hold the receiver off meanwhile.
  task automatic test_backpressure();
    write_hop(11'd1);
    hold_long = 1'b1;
    for (int i = 0; i < 4; i++) send_sample(16'($urandom));
    drain();
  endtask

  // More than a frame is left uncovered at the flush: the tail caps at a frame.
  task automatic test_tail_cap();
    send_flush();
    drain();
  endtask

  task automatic test_random();
    int unsigned pick;
    for (int ph = 0; ph < 2; ph++) begin
      if (ph == 1) no_idle = 1'b1;  // last part runs at full rate
      for (int i = 0; i < 5; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) send_sample(16'($urandom));
        else if (pick < 90) begin
          send_item(stftdb_pkg::REQ_COEF, 16'($urandom), 6'($urandom), 16'($urandom));
        end
        else send_item(REQ_UNUSED, 16'($urandom), 6'($urandom), 16'($urandom));
      end
      send_flush();
      drain();
    end
  endtask

  // Receiver: random pop gaps, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (!no_idle && rst_ni && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  // Compare each popped bin with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (bins_due.size() == 0) begin
        $error("unexpected bin %0d", bin_index_o);
        fail_cnt++;
      end else begin
        stftdb_pkg::res_t e;
        e = bins_due.pop_front();
        if (bin_index_o !== e.bin_index) begin
          $error("bin_index exp %0d got %0d", e.bin_index, bin_index_o);
          fail_cnt++;
        end
        if (level_db_o !== e.level_db) begin
          $error("level_db exp %0d got %0d", e.level_db, level_db_o);
          fail_cnt++;
        end
        if (padded_frame_o !== e.padded_frame) begin
          $error("padded_frame exp %0d got %0d", e.padded_frame, padded_frame_o);
          fail_cnt++;
        end
        if (last_bin_o !== e.last_bin) begin
          $error("last_bin exp %0d got %0d", e.last_bin, last_bin_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run after too long without any beat.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WD_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    wr_slot = 0;
    fill_cnt = 0;
    framed = 1'b0;
    hop_reg = 32;
    build_trig();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_window_load();
    test_tail_frames();
    test_hop_extremes();
    test_backpressure();
    test_tail_cap();
    test_random();
    if (fail_cnt == 0 && bins_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
